[design/tdc_pkg.sv]
// shared types and constants of the time-of-day clock
package tdc_pkg;

	localparam int CmdW    = 3;
	localparam int ValueW  = 6;
	localparam int SecW    = 6;
	localparam int MinW    = 6;
	localparam int HourW   = 5;
	localparam int DayW    = 3;
	localparam int MsW     = 16;
	localparam int HitW    = 8;

	localparam int AlarmCount = 8;
	localparam int AlarmW     = 18;
	localparam int PairW      = 2 * AlarmW;
	localparam int PairCount  = 4;

	localparam int ApbDataW = 64;
	localparam int ApbAddrW = 6;
	localparam int RegIdxW  = 3;

	localparam logic [SecW-1:0]  SecMax  = SecW'(59);
	localparam logic [MinW-1:0]  MinMax  = MinW'(59);
	localparam logic [HourW-1:0] HourMax = HourW'(23);
	localparam logic [DayW-1:0]  DayMax  = DayW'(6);
	localparam logic [MsW-1:0]   MsPerSecondReset = MsW'(1000);

	typedef enum logic [CmdW-1:0] {
		CMD_TICK     = 3'd0,
		CMD_SET_SEC  = 3'd1,
		CMD_SET_MIN  = 3'd2,
		CMD_SET_HOUR = 3'd3,
		CMD_SET_DAY  = 3'd4,
		CMD_READ     = 3'd5
	} cmd_t;

	typedef enum logic [RegIdxW-1:0] {
		REG_MS_PER_SECOND = 3'd0,
		REG_ALARM_PAIR_0  = 3'd1,
		REG_ALARM_PAIR_1  = 3'd2,
		REG_ALARM_PAIR_2  = 3'd3,
		REG_ALARM_PAIR_3  = 3'd4
	} reg_idx_t;

endpackage

[design/tdc_if.sv]
// valid/ready channels for command words and time result words
interface tdc_item_if import tdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CmdW-1:0]   command;
	logic [ValueW-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

interface tdc_result_if import tdc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SecW-1:0]  second_now;
	logic [MinW-1:0]  minute_now;
	logic [HourW-1:0] hour_now;
	logic [DayW-1:0]  weekday_now;
	logic             second_advanced;
	logic             second_event;
	logic             minute_event;
	logic             hour_event;
	logic             weekday_event;
	logic [HitW-1:0]  alarm_hits;
	logic [HitW-1:0]  alarm_latched;

	modport source (
		output valid, output second_now, output minute_now, output hour_now,
		output weekday_now, output second_advanced, output second_event,
		output minute_event, output hour_event, output weekday_event,
		output alarm_hits, output alarm_latched, input ready
	);
	modport sink (
		input valid, input second_now, input minute_now, input hour_now,
		input weekday_now, input second_advanced, input second_event,
		input minute_event, input hour_event, input weekday_event,
		input alarm_hits, input alarm_latched, output ready
	);
endinterface

[design/time_of_day_clock_with_alarms.sv]
// time-of-day clock: prescaler, second/minute/hour/weekday chain, eight alarms
// a taken word sits in the input register; its result word is loaded into the result
//   register once that register is empty or being emptied
// throughput: one word per cycle while the result register is not stalled
// reset: time, prescaler and fired flags clear, ms_per_second goes to 1000,
//   alarm pairs clear (all alarms disabled), both pipeline registers empty
module time_of_day_clock_with_alarms import tdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	tdc_item_if.sink            item,
	tdc_result_if.source        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready
);

	// configuration registers
	logic [MsW-1:0]   ms_per_second_q;
	logic [PairW-1:0] alarm_pair_q [PairCount];

	// clock state
	logic [MsW-1:0]   ms_count_q;
	logic [SecW-1:0]  sec_q;
	logic [MinW-1:0]  min_q;
	logic [HourW-1:0] hour_q;
	logic [DayW-1:0]  day_q;
	logic [HitW-1:0]  fired_q;

	// input register
	logic              valid_s1;
	logic [CmdW-1:0]   command_s1;
	logic [ValueW-1:0] value_s1;

	// result register
	logic             res_valid_q;
	logic [SecW-1:0]  res_sec_q;
	logic [MinW-1:0]  res_min_q;
	logic [HourW-1:0] res_hour_q;
	logic [DayW-1:0]  res_day_q;
	logic             res_adv_q;
	logic             res_sev_q;
	logic             res_mev_q;
	logic             res_hev_q;
	logic             res_dev_q;
	logic [HitW-1:0]  res_hits_q;
	logic [HitW-1:0]  res_fired_q;

	// next-state values for the word in the input register
	logic [MsW-1:0]   ms_n;
	logic [SecW-1:0]  sec_n;
	logic [MinW-1:0]  min_n;
	logic [HourW-1:0] hour_n;
	logic [DayW-1:0]  day_n;
	logic             adv_n;
	logic             sev_n;
	logic             mev_n;
	logic             hev_n;
	logic             dev_n;
	logic [HitW-1:0]  match;
	logic [HitW-1:0]  hits_n;
	logic [MsW:0]     ms_inc;
	logic [ValueW-1:0] sat_sec;
	logic [ValueW-1:0] sat_min;
	logic [ValueW-1:0] sat_hour;
	logic [ValueW-1:0] sat_day;

	logic advance;
	logic cfg_wr;

	// a second that is a multiple of ten raises the second event on ticks
	function automatic logic is_decade(input logic [SecW-1:0] s);
		return (s == SecW'(0)) || (s == SecW'(10)) || (s == SecW'(20)) ||
		       (s == SecW'(30)) || (s == SecW'(40)) || (s == SecW'(50));
	endfunction

	// ---------------------------------------------------------------
	// handshake: the input register moves on when the result register
	// is empty or being emptied; a waiting result does not block intake
	// while the input register itself is free
	// ---------------------------------------------------------------
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1 <= item.command;
			value_s1   <= item.value;
		end
	end

	// ---------------------------------------------------------------
	// configuration port: setup phase then access phase, never waits
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_per_second_q <= MsPerSecondReset;
			for (int k = 0; k < PairCount; k++) begin
				alarm_pair_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[ApbAddrW-1:ApbAddrW-RegIdxW]))
				REG_MS_PER_SECOND: ms_per_second_q <= pwdata[MsW-1:0];
				REG_ALARM_PAIR_0:  alarm_pair_q[0] <= pwdata[PairW-1:0];
				REG_ALARM_PAIR_1:  alarm_pair_q[1] <= pwdata[PairW-1:0];
				REG_ALARM_PAIR_2:  alarm_pair_q[2] <= pwdata[PairW-1:0];
				REG_ALARM_PAIR_3:  alarm_pair_q[3] <= pwdata[PairW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[ApbAddrW-1:ApbAddrW-RegIdxW]))
			REG_MS_PER_SECOND: prdata = ApbDataW'(ms_per_second_q);
			REG_ALARM_PAIR_0:  prdata = ApbDataW'(alarm_pair_q[0]);
			REG_ALARM_PAIR_1:  prdata = ApbDataW'(alarm_pair_q[1]);
			REG_ALARM_PAIR_2:  prdata = ApbDataW'(alarm_pair_q[2]);
			REG_ALARM_PAIR_3:  prdata = ApbDataW'(alarm_pair_q[3]);
			default:           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// time update for the word in the input register
	// ---------------------------------------------------------------
	assign ms_inc   = {1'b0, ms_count_q} + (MsW+1)'(1);
	assign sat_sec  = (value_s1 > ValueW'(SecMax))  ? ValueW'(SecMax)  : value_s1;
	assign sat_min  = (value_s1 > ValueW'(MinMax))  ? ValueW'(MinMax)  : value_s1;
	assign sat_hour = (value_s1 > ValueW'(HourMax)) ? ValueW'(HourMax) : value_s1;
	assign sat_day  = (value_s1 > ValueW'(DayMax))  ? ValueW'(DayMax)  : value_s1;

	always_comb begin
		ms_n   = ms_count_q;
		sec_n  = sec_q;
		min_n  = min_q;
		hour_n = hour_q;
		day_n  = day_q;
		adv_n  = 1'b0;
		sev_n  = 1'b0;
		mev_n  = 1'b0;
		hev_n  = 1'b0;
		dev_n  = 1'b0;
		unique case (cmd_t'(command_s1))
			CMD_TICK: begin
				// a zero divider compares like one: every tick ends a second
				if (ms_inc >= {1'b0, ms_per_second_q}) begin
					ms_n  = '0;
					adv_n = 1'b1;
					if (sec_q >= SecMax) begin
						sec_n = '0;
						mev_n = 1'b1;
						if (min_q >= MinMax) begin
							min_n = '0;
							hev_n = 1'b1;
							if (hour_q >= HourMax) begin
								hour_n = '0;
								dev_n  = 1'b1;
								day_n  = (day_q >= DayMax) ? '0 : day_q + DayW'(1);
							end else begin
								hour_n = hour_q + HourW'(1);
							end
						end else begin
							min_n = min_q + MinW'(1);
						end
					end else begin
						sec_n = sec_q + SecW'(1);
					end
					sev_n = is_decade(sec_n);
				end else begin
					ms_n = ms_inc[MsW-1:0];
				end
			end
			CMD_SET_SEC: begin
				// setting the second always restarts the prescaler
				ms_n  = '0;
				sec_n = SecW'(sat_sec);
				sev_n = (SecW'(sat_sec) != sec_q);
			end
			CMD_SET_MIN: begin
				min_n = MinW'(sat_min);
				mev_n = (MinW'(sat_min) != min_q);
			end
			CMD_SET_HOUR: begin
				hour_n = HourW'(sat_hour);
				hev_n  = (HourW'(sat_hour) != hour_q);
			end
			CMD_SET_DAY: begin
				day_n = DayW'(sat_day);
				dev_n = (DayW'(sat_day) != day_q);
			end
			default: ; // read, and the unused codes act as read
		endcase
	end

	// alarm compare against the new time, eight in parallel
	always_comb begin
		match = '0;
		for (int i = 0; i < AlarmCount; i++) begin
			logic [AlarmW-1:0] a;
			a = alarm_pair_q[i / 2][(i % 2) * AlarmW +: AlarmW];
			match[i] = a[AlarmW-1] &&
			           (a[16:12] == hour_n) &&
			           (a[11:6] == min_n) &&
			           (a[5:0] == sec_n);
		end
	end

	assign hits_n = adv_n ? match : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_count_q <= '0;
			sec_q      <= '0;
			min_q      <= '0;
			hour_q     <= '0;
			day_q      <= '0;
			fired_q    <= '0;
		end else if (advance) begin
			ms_count_q <= ms_n;
			sec_q      <= sec_n;
			min_q      <= min_n;
			hour_q     <= hour_n;
			day_q      <= day_n;
			fired_q    <= fired_q | hits_n;
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_sec_q   <= sec_n;
			res_min_q   <= min_n;
			res_hour_q  <= hour_n;
			res_day_q   <= day_n;
			res_adv_q   <= adv_n;
			res_sev_q   <= sev_n;
			res_mev_q   <= mev_n;
			res_hev_q   <= hev_n;
			res_dev_q   <= dev_n;
			res_hits_q  <= hits_n;
			res_fired_q <= fired_q | hits_n;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.second_now      = res_sec_q;
	assign result.minute_now      = res_min_q;
	assign result.hour_now        = res_hour_q;
	assign result.weekday_now     = res_day_q;
	assign result.second_advanced = res_adv_q;
	assign result.second_event    = res_sev_q;
	assign result.minute_event    = res_mev_q;
	assign result.hour_event      = res_hev_q;
	assign result.weekday_event   = res_dev_q;
	assign result.alarm_hits      = res_hits_q;
	assign result.alarm_latched   = res_fired_q;

`ifndef SYNTHESIS
	// the time registers stay within their ranges
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sec_q <= SecMax) && (min_q <= MinMax) && (hour_q <= HourMax) && (day_q <= DayMax))
		else $error("time register out of range");

	// alarm hits only come with a completed second
	a_hits_need_adv: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_hits_q != '0) |-> res_adv_q)
		else $error("alarm hit without second step");

	// fired flags are sticky
	a_fired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((fired_q & $past(fired_q)) == $past(fired_q)))
		else $error("fired flag cleared");

	// a completed second restarts the prescaler
	a_prescaler_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && adv_n |=> (ms_count_q == '0))
		else $error("prescaler not restarted");

	// a full input register behind a stalled result blocks intake
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !result.ready |-> !item.ready)
		else $error("word taken while both registers full");
`endif

endmodule

[tb/tdc_check_pkg.sv]
// expected-result tracking for the time-of-day clock testbench
package tdc_check_pkg;
	import tdc_pkg::*;

	typedef struct {
		logic [SecW-1:0]  second_now;
		logic [MinW-1:0]  minute_now;
		logic [HourW-1:0] hour_now;
		logic [DayW-1:0]  weekday_now;
		logic             second_advanced;
		logic             second_event;
		logic             minute_event;
		logic             hour_event;
		logic             weekday_event;
		logic [HitW-1:0]  alarm_hits;
		logic [HitW-1:0]  alarm_latched;
	} time_word_t;

	class clock_tracker;
		int unsigned      ms_per_second;
		int unsigned      ms_count;
		int unsigned      sec;
		int unsigned      mins;
		int unsigned      hours;
		int unsigned      day;
		logic [PairW-1:0] alarm_pair [PairCount];
		logic [HitW-1:0]  fired;
		time_word_t       expected_words [$];
		int               errors;

		function new();
			ms_per_second = MsPerSecondReset;
			ms_count = 0;
			sec = 0;
			mins = 0;
			hours = 0;
			day = 0;
			foreach (alarm_pair[k]) alarm_pair[k] = '0;
			fired = '0;
			errors = 0;
		endfunction

		function void write_register(reg_idx_t idx, logic [ApbDataW-1:0] data);
			if (idx == REG_MS_PER_SECOND) begin
				ms_per_second = data[MsW-1:0];
			end else begin
				alarm_pair[idx - REG_ALARM_PAIR_0] = data[PairW-1:0];
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned top);
			return (v > top) ? top : v;
		endfunction

		// alarms whose enabled time equals the current time
		function logic [HitW-1:0] matching_alarms();
			logic [HitW-1:0]   m;
			logic [AlarmW-1:0] a;
			m = '0;
			for (int i = 0; i < AlarmCount; i++) begin
				a = alarm_pair[i / 2] >> ((i % 2) * AlarmW);
				if (a[17] && a[16:12] == hours && a[11:6] == mins && a[5:0] == sec)
					m[i] = 1'b1;
			end
			return m;
		endfunction

		function void note_word(logic [CmdW-1:0] cmd, logic [ValueW-1:0] val);
			time_word_t  w;
			int unsigned v;
			int unsigned nxt;
			w = '{default: '0};
			case (cmd)
				CMD_TICK: begin
					nxt = ms_count + 1;
					if (nxt >= ms_per_second) begin
						ms_count = 0;
						w.second_advanced = 1'b1;
						sec++;
						if (sec >= 60) begin
							sec = 0;
							mins++;
							if (mins >= 60) begin
								mins = 0;
								hours++;
								if (hours >= 24) begin
									hours = 0;
									day++;
									if (day >= 7) day = 0;
									w.weekday_event = 1'b1;
								end
								w.hour_event = 1'b1;
							end
							w.minute_event = 1'b1;
						end
						if (sec % 10 == 0) w.second_event = 1'b1;
						w.alarm_hits = matching_alarms();
						fired = fired | w.alarm_hits;
					end else begin
						ms_count = nxt & 16'hFFFF;
					end
				end
				CMD_SET_SEC: begin
					ms_count = 0;
					v = clamp(val, SecMax);
					if (v != sec) begin
						sec = v;
						w.second_event = 1'b1;
					end
				end
				CMD_SET_MIN: begin
					v = clamp(val, MinMax);
					if (v != mins) begin
						mins = v;
						w.minute_event = 1'b1;
					end
				end
				CMD_SET_HOUR: begin
					v = clamp(val, HourMax);
					if (v != hours) begin
						hours = v;
						w.hour_event = 1'b1;
					end
				end
				CMD_SET_DAY: begin
					v = clamp(val, DayMax);
					if (v != day) begin
						day = v;
						w.weekday_event = 1'b1;
					end
				end
				default: ;
			endcase
			w.second_now = sec;
			w.minute_now = mins;
			w.hour_now = hours;
			w.weekday_now = day;
			w.alarm_latched = fired;
			expected_words.push_back(w);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_word(time_word_t got);
			time_word_t want;
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, got sec %0d", $time,
					got.second_now);
				return;
			end
			want = expected_words.pop_front();
			compare_field("second_now", want.second_now, got.second_now);
			compare_field("minute_now", want.minute_now, got.minute_now);
			compare_field("hour_now", want.hour_now, got.hour_now);
			compare_field("weekday_now", want.weekday_now, got.weekday_now);
			compare_field("second_advanced", want.second_advanced, got.second_advanced);
			compare_field("second_event", want.second_event, got.second_event);
			compare_field("minute_event", want.minute_event, got.minute_event);
			compare_field("hour_event", want.hour_event, got.hour_event);
			compare_field("weekday_event", want.weekday_event, got.weekday_event);
			compare_field("alarm_hits", want.alarm_hits, got.alarm_hits);
			compare_field("alarm_latched", want.alarm_latched, got.alarm_latched);
		endfunction
	endclass

endpackage

[tb/time_of_day_clock_with_alarms_test.sv]
// testbench top: drives command words and register writes, checks every result word
module time_of_day_clock_with_alarms_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tdc_pkg::*;
	import tdc_check_pkg::*;

	// command codes the block treats as a plain read
	localparam logic [CmdW-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [CmdW-1:0] CMD_SPARE_B = 3'd7;

	localparam int PhaseCount    = 8;
	localparam int WordsPerPhase = 180;
	localparam int HoldCycles    = 300;
	localparam int WatchdogLimit = 4000;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	tdc_item_if   item_ch ();
	tdc_result_if result_ch ();

	time_of_day_clock_with_alarms u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	clock_tracker tracker = new();

	// idling knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long receiver hold-off: main flow asks, receiver process counts it out
	int hold_asked = 0;
	int hold_done = 0;

	int sent_words = 0;
	int stall_cycles = 0;

	// shadow of what the testbench wrote, used to aim time sets at alarms
	int unsigned      ms_setting = MsPerSecondReset;
	logic [PairW-1:0] alarm_cfg [PairCount] = '{default: '0};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver side of the result channel
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_done) begin
				hold_done++;
				result_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// acceptance monitor: feeds the tracker and checks result words
	always @(posedge clk) begin
		time_word_t got;
		logic       moved;
		moved = 1'b0;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.second_now = result_ch.second_now;
			got.minute_now = result_ch.minute_now;
			got.hour_now = result_ch.hour_now;
			got.weekday_now = result_ch.weekday_now;
			got.second_advanced = result_ch.second_advanced;
			got.second_event = result_ch.second_event;
			got.minute_event = result_ch.minute_event;
			got.hour_event = result_ch.hour_event;
			got.weekday_event = result_ch.weekday_event;
			got.alarm_hits = result_ch.alarm_hits;
			got.alarm_latched = result_ch.alarm_latched;
			tracker.check_word(got);
			moved = 1'b1;
		end
		if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) begin
			tracker.note_word(item_ch.command, item_ch.value);
			moved = 1'b1;
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
	end

	// watchdog: too long without any word moving means the block hung
	initial begin
		while (stall_cycles < WatchdogLimit) @(posedge clk);
		$display("time_of_day_clock_with_alarms_test: done, errors");
		$finish;
	end

	// one command word, with random idle cycles in front of it
	task automatic send_word(logic [CmdW-1:0] cmd, logic [ValueW-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.value <= val;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		sent_words++;
	endtask

	// stop offering words and wait for every expected result word
	task automatic wait_drained(int settle);
		item_ch.valid <= 1'b0;
		// let the monitor log the last accepted word before checking the queue
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// apb write: setup phase, access phase, then psel low again
	task automatic write_reg(reg_idx_t idx, logic [ApbDataW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ApbAddrW'({idx, 3'b000});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		tracker.write_register(idx, data);
		if (idx == REG_MS_PER_SECOND) begin
			ms_setting = data[MsW-1:0];
		end else begin
			alarm_cfg[idx - REG_ALARM_PAIR_0] = data[PairW-1:0];
		end
		@(posedge clk);
	endtask

	task automatic write_pairs(logic [PairW-1:0] p0, logic [PairW-1:0] p1,
		logic [PairW-1:0] p2, logic [PairW-1:0] p3);
		write_reg(REG_ALARM_PAIR_0, ApbDataW'(p0));
		write_reg(REG_ALARM_PAIR_1, ApbDataW'(p1));
		write_reg(REG_ALARM_PAIR_2, ApbDataW'(p2));
		write_reg(REG_ALARM_PAIR_3, ApbDataW'(p3));
	endtask

	function automatic logic [AlarmW-1:0] alarm_entry(bit en, int h, int m, int s);
		return {en, HourW'(h), MinW'(m), SecW'(s)};
	endfunction

	// mostly reachable times, now and then an hour, minute or second out of range
	function automatic logic [AlarmW-1:0] random_alarm();
		int h;
		int m;
		int s;
		h = ($urandom_range(9) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
		m = ($urandom_range(9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
		s = ($urandom_range(9) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
		return alarm_entry($urandom_range(3) != 0, h, m, s);
	endfunction

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 58;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 58;
			end
			default: begin
				send_idle_pct = 15;
				recv_stall_pct = 15;
			end
		endcase
	endtask

	// set the clock up to three seconds short of one alarm's time, then tick towards it
	task automatic aim_at_alarm();
		int                k;
		int                d;
		int                reps;
		logic [AlarmW-1:0] a;
		k = $urandom_range(AlarmCount - 1);
		a = alarm_cfg[k / 2] >> ((k % 2) * AlarmW);
		d = $urandom_range(1, 3);
		send_word(CMD_SET_HOUR, ValueW'(a[16:12]));
		send_word(CMD_SET_MIN, a[11:6]);
		send_word(CMD_SET_SEC, (a[5:0] >= d) ? ValueW'(a[5:0] - d) : a[5:0]);
		if (ms_setting > 8)
			reps = $urandom_range(1, 4);
		else
			reps = d * ((ms_setting == 0) ? 1 : ms_setting) + $urandom_range(0, 2);
		repeat (reps) send_word(CMD_TICK, ValueW'($urandom));
	endtask

	// one random word: ticks dominate, sets and reads mixed in
	task automatic random_word();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			send_word(CMD_TICK, ValueW'($urandom));
		else if (r < 85)
			send_word(CmdW'($urandom_range(CMD_SET_SEC, CMD_SET_DAY)), ValueW'($urandom));
		else
			send_word(CmdW'($urandom_range(CMD_READ, CMD_SPARE_B)), ValueW'($urandom));
	endtask

	initial begin
		int  phase_start;
		int  ms;
		bit  paused;
		item_ch.valid <= 1'b0;
		item_ch.command <= CMD_READ;
		item_ch.value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: reads, unused codes, saturating and no-change sets
		send_word(CMD_READ, '0);
		send_word(CMD_SPARE_A, ValueW'(63));
		send_word(CMD_SPARE_B, ValueW'(21));
		send_word(CMD_SET_SEC, '0);
		send_word(CMD_SET_SEC, ValueW'(63));
		send_word(CMD_SET_MIN, ValueW'(63));
		send_word(CMD_SET_HOUR, ValueW'(63));
		send_word(CMD_SET_DAY, ValueW'(63));
		send_word(CMD_SET_DAY, ValueW'(6));
		// three ticks at 1000 per second leave the prescaler count at three
		repeat (3) send_word(CMD_TICK, ValueW'(63));

		// divider lowered below the count: next tick completes the second,
		// here from sunday 23:59:59 so every field rolls over
		wait_drained(4);
		write_reg(REG_MS_PER_SECOND, ApbDataW'(2));
		send_word(CMD_TICK, '0);

		// zero divider, every tick a second; alarm table with two alarms on the
		// same time, a disabled match, and unreachable hour and minute
		wait_drained(4);
		write_reg(REG_MS_PER_SECOND, '0);
		write_pairs({alarm_entry(0, 0, 0, 3), alarm_entry(1, 0, 0, 2)},
			{alarm_entry(1, 0, 0, 3), alarm_entry(1, 31, 0, 3)},
			{alarm_entry(1, 0, 63, 1), alarm_entry(1, 0, 0, 2)},
			{{AlarmW{1'b1}}, alarm_entry(1, 0, 0, 0)});
		repeat (3) send_word(CMD_TICK, '0);
		send_word(CMD_SET_SEC, ValueW'(59));
		send_word(CMD_TICK, '0);
		send_word(CMD_SET_HOUR, '0);
		send_word(CMD_SET_MIN, ValueW'(59));
		send_word(CMD_SET_SEC, ValueW'(59));
		send_word(CMD_SET_HOUR, ValueW'(23));
		// midnight again: weekday rolls, alarm at 00:00:00 fires
		send_word(CMD_TICK, '0);

		// random phases, each with its own divider, alarm table and idling
		for (int p = 0; p < PhaseCount; p++) begin
			wait_drained(4);
			if (p == 0)
				ms = 1;
			else if (p == 1)
				ms = 65535;
			else if (p == 7)
				ms = $urandom_range(5, 12);
			else
				ms = $urandom_range(0, 4);
			write_reg(REG_MS_PER_SECOND, ApbDataW'(ms));
			if (p == 1)
				write_pairs('1, '1, '1, '1);
			else if (p == 5)
				write_pairs('0, '0, '0, '0);
			else
				write_pairs({random_alarm(), random_alarm()}, {random_alarm(), random_alarm()},
					{random_alarm(), random_alarm()}, {random_alarm(), random_alarm()});
			set_idling(idle_mode_t'(p % 4));
			// receiver goes quiet for a long stretch while words keep coming
			if (p == 2) hold_asked++;
			phase_start = sent_words;
			paused = 1'b0;
			while (sent_words - phase_start < WordsPerPhase) begin
				// sender pause half way until all results are back
				if (p == 4 && !paused && sent_words - phase_start >= WordsPerPhase / 2) begin
					wait_drained(2);
					paused = 1'b1;
				end
				if ($urandom_range(99) < 12)
					aim_at_alarm();
				else
					random_word();
			end
		end

		wait_drained(8);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("time_of_day_clock_with_alarms_test: done, clean");
		else
			$display("time_of_day_clock_with_alarms_test: done, errors");
		$finish;
	end

endmodule
